### rtl/bcs_pkg.sv
// Package for the backtracking constraint solver.
// Shared constants, codes, types and the relate function; no dependencies.
package bcs_pkg;
  localparam int MaxVars = 16;
  localparam int MaxRules = 64;
  localparam int ValueBits = 8;
  localparam int VarBits = 4;
  localparam int RuleBits = 6;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpDom = 2'd1;
  localparam logic [1:0] OpSolve = 2'd2;

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StValue = 2'd2;
  localparam logic [1:0] StNone = 2'd3;

  localparam logic [2:0] RelEq = 3'd0;
  localparam logic [2:0] RelNe = 3'd1;
  localparam logic [2:0] RelLt = 3'd2;
  localparam logic [2:0] RelGt = 3'd3;
  localparam logic [2:0] RelLe = 3'd4;
  localparam logic [2:0] RelGe = 3'd5;

  typedef struct packed {
    logic [VarBits-1:0] a;
    logic [VarBits-1:0] b;
    logic [2:0] rel;
    logic absm;
    logic signed [8:0] k;
  } rule_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_RREQ, S_RCHK, S_ACCEPT, S_BACK, S_OREQ, S_OUT
  } state_t;

  function automatic logic relate(input logic [2:0] rel, input logic signed [10:0] x,
                                  input logic signed [10:0] y);
    logic r;
    unique case (rel)
      RelEq: r = (x == y);
      RelNe: r = (x != y);
      RelLt: r = (x < y);
      RelGt: r = (x > y);
      RelLe: r = (x <= y);
      RelGe: r = (x >= y);
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

### rtl/bcs_rule_mem.sv
// Rule memory: one write port, one registered read port.
// Depends on bcs_pkg.
module bcs_rule_mem (
  input  logic clk,
  input  logic we,
  input  logic [bcs_pkg::RuleBits-1:0] waddr,
  input  bcs_pkg::rule_t wdata,
  input  logic [bcs_pkg::RuleBits-1:0] raddr,
  output bcs_pkg::rule_t rdata
);
  bcs_pkg::rule_t mem [bcs_pkg::MaxRules];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/bcs_val_mem.sv
// Assigned value memory, one write port, one registered read port.
// Depends on bcs_pkg.
module bcs_val_mem (
  input  logic clk,
  input  logic we,
  input  logic [bcs_pkg::VarBits-1:0] waddr,
  input  logic signed [bcs_pkg::ValueBits-1:0] wdata,
  input  logic [bcs_pkg::VarBits-1:0] raddr,
  output logic signed [bcs_pkg::ValueBits-1:0] rdata
);
  logic signed [bcs_pkg::ValueBits-1:0] mem [bcs_pkg::MaxVars];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/backtracking_constraint_solver.sv
// Top level of the backtracking constraint solver: command decode and search sequencer.
// Depends on bcs_pkg, bcs_rule_mem, bcs_val_mem.
//
//   channel   signals                                         direction
//   request   start busy op var_a var_b relation abs_mode ... in
//   result    strobe status var_index value last              out
//   config    num_vars_we num_vars_wdata                      in
//
// Rule and domain requests are accepted while idle, with the result registered on the next cycle.
// Solve: each candidate scans the rule memory, stepping through bound check,
// rule read and value read for each stored rule, then is accepted; a backtrack
// step is the S_BACK state; output reads each variable in S_OREQ then S_OUT.
// Reset clears rule count, domains and num_vars (to 1). The receiver
// cannot stall; busy holds off requests while a solve runs.
module backtracking_constraint_solver (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] op,
  input  logic [3:0] var_a,
  input  logic [3:0] var_b,
  input  logic [2:0] relation,
  input  logic abs_mode,
  input  logic signed [8:0] rule_const,
  input  logic signed [7:0] dom_min,
  input  logic signed [7:0] dom_max,
  input  logic num_vars_we,
  input  logic [4:0] num_vars_wdata,
  output logic strobe,
  output logic [1:0] status,
  output logic [3:0] var_index,
  output logic signed [7:0] value,
  output logic last
);
  localparam int VB = bcs_pkg::ValueBits;
  localparam int XB = bcs_pkg::VarBits;
  localparam int RB = bcs_pkg::RuleBits;

  bcs_pkg::state_t state, state_next;
  logic [4:0] num_vars;
  logic [RB:0] rule_count;
  logic signed [VB-1:0] dlo [bcs_pkg::MaxVars];
  logic signed [VB-1:0] dhi [bcs_pkg::MaxVars];
  logic signed [VB:0] cand [bcs_pkg::MaxVars];
  logic [XB-1:0] depth;
  logic [4:0] nv;
  logic [RB:0] ridx;
  bcs_pkg::rule_t rule_q;

  logic rwe;
  bcs_pkg::rule_t rwdata, rrdata;
  logic vwe;
  logic [XB-1:0] vraddr;
  logic signed [VB-1:0] vrdata;

  always_comb begin
    rwdata.a = var_a;
    rwdata.b = var_b;
    rwdata.rel = relation;
    rwdata.absm = abs_mode;
    rwdata.k = rule_const;
  end

  assign busy = (state != bcs_pkg::S_IDLE);
  logic acc;
  assign acc = start && !busy;
  assign rwe = acc && op == bcs_pkg::OpAdd && !rule_count[RB];

  bcs_rule_mem u_rules (
    .clk(clk), .we(rwe), .waddr(rule_count[RB-1:0]), .wdata(rwdata),
    .raddr(ridx[RB-1:0]), .rdata(rrdata)
  );

  // rule word is held on the read port while ridx is steady
  assign rule_q = rrdata;

  // other end of the rule being checked; rules apply only if other < depth
  logic ina, inb, applies;
  logic [XB-1:0] other;
  always_comb begin
    ina = (rule_q.a == depth);
    inb = (rule_q.b == depth);
    other = ina ? rule_q.b : rule_q.a;
    applies = (ina || inb) && (other < depth);
  end

  assign vraddr = (state == bcs_pkg::S_OREQ) ? depth : other;
  assign vwe = (state == bcs_pkg::S_ACCEPT);

  bcs_val_mem u_vals (
    .clk(clk), .we(vwe), .waddr(depth), .wdata(cand[depth][VB-1:0]),
    .raddr(vraddr), .rdata(vrdata)
  );

  logic signed [10:0] cv, ov, x, y, d;
  logic ok;
  always_comb begin
    cv = 11'(cand[depth]);
    ov = 11'(vrdata);
    x = ina ? cv : ov;
    y = ina ? ov : cv;
    d = x - y;
    if (d < 0) d = -d;
    if (rule_q.absm) ok = bcs_pkg::relate(rule_q.rel, d, 11'(rule_q.k));
    else ok = bcs_pkg::relate(rule_q.rel, x, y);
  end

  logic [4:0] nclamp;
  always_comb begin
    if (num_vars == 5'd0) nclamp = 5'd1;
    else if (num_vars > 5'(bcs_pkg::MaxVars)) nclamp = 5'(bcs_pkg::MaxVars);
    else nclamp = num_vars;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bcs_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bcs_pkg::S_IDLE: if (acc && op == bcs_pkg::OpSolve) state_next = bcs_pkg::S_NEXT;
      bcs_pkg::S_NEXT: begin
        if (cand[depth] > 9'(dlo[depth]) && cand[depth] > 9'(dhi[depth]))
          state_next = bcs_pkg::S_BACK;
        else if (cand[depth] > 9'(dhi[depth])) state_next = bcs_pkg::S_BACK;
        else if (ridx >= rule_count) state_next = bcs_pkg::S_ACCEPT;
        else state_next = bcs_pkg::S_RREQ;
      end
      bcs_pkg::S_RREQ: state_next = bcs_pkg::S_RCHK;
      bcs_pkg::S_RCHK: state_next = bcs_pkg::S_NEXT;
      bcs_pkg::S_ACCEPT: state_next = (5'(depth) + 5'd1 >= nv) ? bcs_pkg::S_OREQ
                                                               : bcs_pkg::S_NEXT;
      bcs_pkg::S_BACK: state_next = (depth == '0) ? bcs_pkg::S_IDLE : bcs_pkg::S_NEXT;
      bcs_pkg::S_OREQ: state_next = bcs_pkg::S_OUT;
      bcs_pkg::S_OUT: state_next = (5'(depth) + 5'd1 >= nv) ? bcs_pkg::S_IDLE
                                                            : bcs_pkg::S_OREQ;
      default: state_next = bcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars <= 5'd1;
      rule_count <= '0;
      for (int i = 0; i < bcs_pkg::MaxVars; i++) begin
        dlo[i] <= '0;
        dhi[i] <= '0;
      end
      strobe <= 1'b0;
      depth <= '0;
      ridx <= '0;
    end else begin
      strobe <= 1'b0;
      if (num_vars_we) num_vars <= num_vars_wdata;
      unique case (state)
        bcs_pkg::S_IDLE: begin
          if (acc) begin
            unique case (op)
              bcs_pkg::OpAdd: begin
                strobe <= 1'b1;
                status <= rule_count[RB] ? bcs_pkg::StFull : bcs_pkg::StAccepted;
                var_index <= '0; value <= '0; last <= 1'b1;
                if (!rule_count[RB]) rule_count <= rule_count + 1'b1;
              end
              bcs_pkg::OpDom: begin
                strobe <= 1'b1;
                status <= bcs_pkg::StAccepted;
                var_index <= '0; value <= '0; last <= 1'b1;
                dlo[var_a] <= dom_min;
                dhi[var_a] <= dom_max;
              end
              bcs_pkg::OpSolve: begin
                nv <= nclamp;
                depth <= '0;
                ridx <= '0;
                cand[0] <= 9'(dlo[0]);
              end
              default: ;
            endcase
          end
        end
        bcs_pkg::S_NEXT: ;
        bcs_pkg::S_RREQ: ;
        bcs_pkg::S_RCHK: begin
          if (applies && !ok) begin
            cand[depth] <= cand[depth] + 1'b1;
            ridx <= '0;
          end else ridx <= ridx + 1'b1;
        end
        bcs_pkg::S_ACCEPT: begin
          ridx <= '0;
          if (5'(depth) + 5'd1 >= nv) depth <= '0;
          else begin
            depth <= depth + 1'b1;
            cand[depth + 1'b1] <= 9'(dlo[depth + 1'b1]);
          end
        end
        bcs_pkg::S_BACK: begin
          ridx <= '0;
          if (depth == '0) begin
            strobe <= 1'b1;
            status <= bcs_pkg::StNone;
            var_index <= '0; value <= '0; last <= 1'b1;
          end else begin
            depth <= depth - 1'b1;
            cand[depth - 1'b1] <= cand[depth - 1'b1] + 1'b1;
          end
        end
        bcs_pkg::S_OREQ: ;
        bcs_pkg::S_OUT: begin
          strobe <= 1'b1;
          status <= bcs_pkg::StValue;
          var_index <= depth;
          value <= vrdata;
          last <= (5'(depth) + 5'd1 >= nv);
          depth <= depth + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

### verif/backtracking_constraint_solver_test.sv
// Self-checking testbench for backtracking_constraint_solver.
// A directed table then random rule, domain, solve and invalid-op requests, all checked
// against a behavioral search model in this file; depends on bcs_pkg.
`timescale 1ns / 1ps

module backtracking_constraint_solver_test;
  localparam int WatchLimit = 200000;

  typedef struct {
    logic [1:0] status;
    logic [3:0] idx;
    logic signed [7:0] val;
    logic last;
  } answer_t;

  typedef struct {
    int cfg;
    logic [1:0] op;
    logic [3:0] a;
    logic [3:0] b;
    logic [2:0] rel;
    logic absm;
    logic signed [8:0] k;
    logic signed [7:0] lo;
    logic signed [7:0] hi;
    bit chk;
    logic [1:0] st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = '0;
  logic [3:0] var_a = '0;
  logic [3:0] var_b = '0;
  logic [2:0] relation = '0;
  logic abs_mode = 1'b0;
  logic signed [8:0] rule_const = '0;
  logic signed [7:0] dom_min = '0;
  logic signed [7:0] dom_max = '0;
  logic num_vars_we = 1'b0;
  logic [4:0] num_vars_wdata = '0;
  logic strobe;
  logic [1:0] status;
  logic [3:0] var_index;
  logic signed [7:0] value;
  logic last;

  backtracking_constraint_solver i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .var_a(var_a),
    .var_b(var_b), .relation(relation), .abs_mode(abs_mode), .rule_const(rule_const),
    .dom_min(dom_min), .dom_max(dom_max), .num_vars_we(num_vars_we),
    .num_vars_wdata(num_vars_wdata), .strobe(strobe), .status(status),
    .var_index(var_index), .value(value), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // solver model state
  int rule_a[bcs_pkg::MaxRules];
  int rule_b[bcs_pkg::MaxRules];
  int rule_rel[bcs_pkg::MaxRules];
  bit rule_abs[bcs_pkg::MaxRules];
  int rule_k[bcs_pkg::MaxRules];
  int rules_held;
  int dom_lo[bcs_pkg::MaxVars];
  int dom_hi[bcs_pkg::MaxVars];
  int held_val[bcs_pkg::MaxVars];
  bit held[bcs_pkg::MaxVars];
  int vars_used;

  answer_t answers_due[$];
  int mismatches;
  int requests, solved, unsolvable, full_seen;
  int idle_cnt;
  int gap_pct;

  function automatic void queue_answer(input answer_t a);
    answers_due.insert(answers_due.size(), a);
  endfunction

  function automatic bit rel_holds(int rel, int x, int y);
    case (rel)
      bcs_pkg::RelEq: return x == y;
      bcs_pkg::RelNe: return x != y;
      bcs_pkg::RelLt: return x < y;
      bcs_pkg::RelGt: return x > y;
      bcs_pkg::RelLe: return x <= y;
      bcs_pkg::RelGe: return x >= y;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit value_fits(int t, int v);
    int other, x, y, d;
    bit ina, inb;
    for (int i = 0; i < rules_held; i++) begin
      ina = (rule_a[i] == t);
      inb = (rule_b[i] == t);
      if (!ina && !inb) continue;
      other = ina ? rule_b[i] : rule_a[i];
      if (other >= bcs_pkg::MaxVars || !held[other]) continue;
      x = ina ? v : held_val[other];
      y = ina ? held_val[other] : v;
      if (rule_abs[i]) begin
        d = (x > y) ? x - y : y - x;
        if (!rel_holds(rule_rel[i], d, rule_k[i])) return 1'b0;
      end else if (!rel_holds(rule_rel[i], x, y)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit find_assignment(int n);
    int cand[bcs_pkg::MaxVars];
    int d;
    for (int i = 0; i < bcs_pkg::MaxVars; i++) held[i] = 1'b0;
    d = 0;
    cand[0] = dom_lo[0];
    forever begin
      if (d >= n) return 1'b1;
      if (cand[d] > dom_hi[d]) begin
        if (d == 0) return 1'b0;
        d = d - 1;
        held[d] = 1'b0;
        cand[d]++;
      end else if (value_fits(d, cand[d])) begin
        held_val[d] = cand[d];
        held[d] = 1'b1;
        d = d + 1;
        if (d < n) cand[d] = dom_lo[d];
      end else begin
        cand[d]++;
      end
    end
  endfunction

  task automatic predict_request(input row_t r);
    answer_t ans;
    int n;
    ans = '{bcs_pkg::StAccepted, 4'd0, 8'sd0, 1'b1};
    case (r.op)
      bcs_pkg::OpAdd: begin
        if (rules_held >= bcs_pkg::MaxRules) begin
          ans.status = bcs_pkg::StFull;
          full_seen++;
        end else begin
          rule_a[rules_held] = r.a;
          rule_b[rules_held] = r.b;
          rule_rel[rules_held] = r.rel;
          rule_abs[rules_held] = r.absm;
          rule_k[rules_held] = r.k;
          rules_held++;
        end
        queue_answer(ans);
      end
      bcs_pkg::OpDom: begin
        dom_lo[r.a] = r.lo;
        dom_hi[r.a] = r.hi;
        queue_answer(ans);
      end
      bcs_pkg::OpSolve: begin
        n = (vars_used < 1) ? 1 : (vars_used > bcs_pkg::MaxVars) ? bcs_pkg::MaxVars
                                                                 : vars_used;
        if (!find_assignment(n)) begin
          ans.status = bcs_pkg::StNone;
          queue_answer(ans);
          unsolvable++;
        end else begin
          for (int i = 0; i < n; i++) begin
            ans = '{bcs_pkg::StValue, 4'(i), 8'(held_val[i]), (i == n - 1)};
            queue_answer(ans);
          end
          solved++;
        end
      end
      default: ;
    endcase
  endtask

  // results
  always @(posedge clk) begin
    answer_t e;
    if (!rst && ((start && !busy) || strobe)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (!rst && strobe) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d idx %0d value %0d last %0d",
                   status, var_index, value, last);
      end else begin
        e = answers_due.pop_front();
        if (e.status !== status || e.idx !== var_index || e.val !== value ||
            e.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d idx %0d val %0d last %0d, got %0d %0d %0d %0d",
                     e.status, e.idx, e.val, e.last, status, var_index, value, last);
        end
      end
    end
    if (idle_cnt > WatchLimit) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input row_t r);
    int due_before;
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    op = r.op; var_a = r.a; var_b = r.b; relation = r.rel; abs_mode = r.absm;
    rule_const = r.k; dom_min = r.lo; dom_max = r.hi;
    do @(posedge clk); while (busy);
    requests++;
    due_before = answers_due.size();
    predict_request(r);
    if (r.chk && (answers_due.size() == due_before ||
                  answers_due[due_before].status !== r.st)) begin
      mismatches++;
      if (mismatches <= 10) $display("table row status %0d not predicted", r.st);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vars(input int n);
    drain();
    @(negedge clk);
    num_vars_we = 1'b1;
    num_vars_wdata = 5'(n);
    @(negedge clk);
    num_vars_we = 1'b0;
    vars_used = n;
  endtask

  function automatic row_t mk(int cfg, logic [1:0] o, int a, int b, int rel, bit absm,
                              int k, int lo, int hi, bit chk, logic [1:0] st);
    row_t r;
    r = '{cfg, o, 4'(a), 4'(b), 3'(rel), absm, 9'(k), 8'(lo), 8'(hi), chk, st};
    return r;
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int pick, lo, hi;
    pick = $urandom_range(99);
    r = mk(-1, bcs_pkg::OpAdd, $urandom_range(15), $urandom_range(15), $urandom_range(5),
           $urandom_range(1), 0, 0, 0, 0, bcs_pkg::StAccepted);
    r.k = 9'($urandom);
    r.lo = 8'($urandom);
    r.hi = 8'($urandom);
    if ($urandom_range(19) == 0) r.rel = 3'($urandom_range(7, 6));
    if (pick < 30) begin
      r.op = bcs_pkg::OpAdd;
    end else if (pick < 70) begin
      r.op = bcs_pkg::OpDom;
      if ($urandom_range(2) != 0) r.a = 4'($urandom_range(3));
      if ($urandom_range(4) == 0) lo = int'($signed(8'($urandom)));
      else lo = int'($urandom_range(6)) - 3;
      r.lo = 8'(lo);
      hi = lo + int'($urandom_range(1));
      if ($urandom_range(9) == 0 && lo > -128) r.hi = 8'(lo - 1);
      else r.hi = 8'((hi > 127) ? 127 : hi);
    end else if (pick < 95) begin
      r.op = bcs_pkg::OpSolve;
    end else begin
      r.op = 2'd3;
    end
    return r;
  endfunction

  row_t plan[$];

  function automatic void add_row(input row_t r);
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    int phase_n[4];
    int phase_gap[4];
    mismatches = 0; requests = 0; solved = 0; unsolvable = 0; full_seen = 0;
    idle_cnt = 0; gap_pct = 0; rules_held = 0; vars_used = 1;
    for (int i = 0; i < bcs_pkg::MaxVars; i++) begin
      dom_lo[i] = 0; dom_hi[i] = 0; held[i] = 0; held_val[i] = 0;
    end
    phase_n = '{3, 1, 4, 2};
    phase_gap = '{0, 58, 0, 6};

    add_row(mk(16, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 1, bcs_pkg::StValue));
    add_row(mk(31, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 1, bcs_pkg::StValue));
    add_row(mk(0, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 1, bcs_pkg::StValue));
    add_row(mk(-1, 2'd3, 15, 15, 7, 1, -1, -1, -1, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpDom, 0, 0, 0, 0, 0, -128, 127, 1, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 1, bcs_pkg::StValue));
    add_row(mk(-1, bcs_pkg::OpDom, 15, 0, 0, 0, 0, 127, -128, 1, bcs_pkg::StAccepted));
    add_row(mk(2, bcs_pkg::OpDom, 1, 0, 0, 0, 0, 0, 3, 1, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 0, 1, bcs_pkg::RelGt, 0, 0, 0, 0, 1,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 1, 1, bcs_pkg::RelEq, 0, 0, 0, 0, 0,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 0, 5, bcs_pkg::RelEq, 0, 0, 0, 0, 0,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 0, 1, bcs_pkg::RelGe, 1, 3, 0, 0, 0,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 0, 1, bcs_pkg::RelLt, 1, 255, 0, 0, 0,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 1, 0, bcs_pkg::RelNe, 1, -256, 0, 0, 0,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 0, 1, bcs_pkg::RelLe, 1, 200, 0, 0, 0,
               bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpDom, 0, 0, 0, 0, 0, 0, 3, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpDom, 15, 0, 0, 0, 0, 0, 0, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 14, 15, 7, 1, 0, 0, 0, 0, bcs_pkg::StAccepted));
    add_row(mk(16, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 1, bcs_pkg::StNone));
    add_row(mk(3, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpDom, 2, 0, 0, 0, 0, 5, 4, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpSolve, 0, 0, 0, 0, 0, 0, 0, 1, bcs_pkg::StNone));
    add_row(mk(-1, bcs_pkg::OpDom, 2, 0, 0, 0, 0, -1, 1, 0, bcs_pkg::StAccepted));
    add_row(mk(-1, bcs_pkg::OpAdd, 6, 9, 6, 0, 0, 0, 0, 0, bcs_pkg::StAccepted));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg >= 0) set_vars(plan[i].cfg);
      send(plan[i]);
    end

    for (int p = 0; p < 4; p++) begin
      set_vars(phase_n[p]);
      gap_pct = phase_gap[p];
      for (int j = 0; j < 64; j++) send(rand_row());
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d requests: %0d solutions, %0d unsolvable, %0d rejected by full table",
             requests, solved, unsolvable, full_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### sim.f
rtl/bcs_pkg.sv
rtl/bcs_rule_mem.sv
rtl/bcs_val_mem.sv
rtl/backtracking_constraint_solver.sv
verif/backtracking_constraint_solver_test.sv
